@@ sv/cmac_pkg.sv @@
package cmac_pkg;

  // Field widths
  localparam int YEAR_W    = 12;
  localparam int MONTH_W   = 4;
  localparam int DAY_W     = 5;
  localparam int HOUR_W    = 5;
  localparam int MINUTE_W  = 6;
  localparam int WDAY_W    = 3;
  localparam int ADV_W     = 8;
  localparam int ALARM_W   = 16;
  localparam int CFG_IDX_W = 2;

  // Defaults for the top level parameters
  localparam int DEFAULT_NUM_ALARMS  = 4;
  localparam int DEFAULT_MAX_CATCHUP = 128;

  // Calendar constants
  localparam int MINUTES_PER_HOUR = 60;
  localparam int HOURS_PER_DAY    = 24;
  localparam int DAYS_PER_WEEK    = 7;
  localparam int MONTHS_PER_YEAR  = 12;
  localparam logic [DAY_W-1:0] LEAP_FEB_DAYS  = 5'd29;
  localparam logic [DAY_W-1:0] LONG_MONTH     = 5'd31;
  localparam logic [MONTH_W-1:0] MONTH_FEB    = 4'd1;

  // Reciprocal of 100 for a 12-bit year: q = (y * 5243) >> 19
  localparam logic [12:0] RECIP_100   = 13'd5243;
  localparam int          RECIP_SHIFT = 19;

  // Cursor value after reset
  localparam logic [YEAR_W-1:0]   RESET_YEAR    = 12'd1970;
  localparam logic [MONTH_W-1:0]  RESET_MONTH   = 4'd0;
  localparam logic [DAY_W-1:0]    RESET_DAY     = 5'd1;
  localparam logic [HOUR_W-1:0]   RESET_HOUR    = 5'd0;
  localparam logic [MINUTE_W-1:0] RESET_MINUTE  = 6'd0;
  localparam logic [WDAY_W-1:0]   RESET_WEEKDAY = 3'd4;

  // Alarm word layout
  localparam int ALM_EN_BIT  = 15;
  localparam int ALM_ANY_BIT = 14;
  localparam int ALM_WD_LSB  = 11;
  localparam int ALM_HR_LSB  = 6;
  localparam int ALM_MN_LSB  = 0;

  // Request operation codes
  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_CATCHUP = 1'b1;

  localparam logic [DAY_W-1:0] MONTH_LEN [MONTHS_PER_YEAR] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;
    logic start;
    logic step;
    logic finish;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic earlier;
    logic at_limit;
  } status_t;

  // Days in a month; months past December count as long months
  function automatic logic [DAY_W-1:0] month_days(logic [MONTH_W-1:0] m, logic leap);
    logic [DAY_W-1:0] len;
    if (m >= MONTH_W'(MONTHS_PER_YEAR)) begin
      len = LONG_MONTH;
    end else if (m == MONTH_FEB && leap) begin
      len = LEAP_FEB_DAYS;
    end else begin
      len = MONTH_LEN[m];
    end
    return len;
  endfunction

endpackage

@@ sv/cmac_ctrl.sv @@
module cmac_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              op,
  output logic              out_valid,
  input  logic              out_ready,
  input  cmac_pkg::status_t status,
  output cmac_pkg::cmd_t    cmd
);
  import cmac_pkg::*;

  state_t state;
  state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = (op == OP_CATCHUP) ? ST_RUN : ST_DONE;
        end
      end
      ST_RUN: begin
        if (!status.earlier || status.at_limit) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.load  = in_valid && (op == OP_LOAD);
        cmd.start = in_valid && (op == OP_CATCHUP);
      end
      ST_RUN: begin
        cmd.step   = status.earlier && !status.at_limit;
        cmd.finish = !status.earlier || status.at_limit;
      end
      ST_DONE: begin
        out_valid = 1'b1;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

@@ sv/cmac_dp.sv @@
module cmac_dp #(
  parameter int NUM_ALARMS  = cmac_pkg::DEFAULT_NUM_ALARMS,
  parameter int MAX_CATCHUP = cmac_pkg::DEFAULT_MAX_CATCHUP
) (
  input  logic                            clk,
  input  logic                            rst,
  input  cmac_pkg::cmd_t                  cmd,
  output cmac_pkg::status_t               status,
  input  logic [cmac_pkg::YEAR_W-1:0]     in_year,
  input  logic [cmac_pkg::MONTH_W-1:0]    in_month,
  input  logic [cmac_pkg::DAY_W-1:0]      in_day,
  input  logic [cmac_pkg::HOUR_W-1:0]     in_hour,
  input  logic [cmac_pkg::MINUTE_W-1:0]   in_minute,
  input  logic [cmac_pkg::WDAY_W-1:0]     in_weekday,
  input  logic                            cfg_we,
  input  logic [cmac_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cmac_pkg::ALARM_W-1:0]    cfg_data,
  output logic                            alarm_fired,
  output logic [cmac_pkg::ADV_W-1:0]      minutes_advanced,
  output logic                            not_reached,
  output logic [cmac_pkg::HOUR_W-1:0]     cur_hour,
  output logic [cmac_pkg::MINUTE_W-1:0]   cur_minute,
  output logic [cmac_pkg::WDAY_W-1:0]     cur_weekday
);
  import cmac_pkg::*;

  localparam int CNT_W = $clog2(MAX_CATCHUP + 1);
  localparam int CMP_W = YEAR_W + MONTH_W + DAY_W + HOUR_W + MINUTE_W;

  // Cursor
  logic [YEAR_W-1:0]   cursor_year,    cursor_year_next;
  logic [MONTH_W-1:0]  cursor_month,   cursor_month_next;
  logic [DAY_W-1:0]    cursor_day,     cursor_day_next;
  logic [HOUR_W-1:0]   cursor_hour,    cursor_hour_next;
  logic [MINUTE_W-1:0] cursor_minute,  cursor_minute_next;
  logic [WDAY_W-1:0]   cursor_weekday, cursor_weekday_next;

  // Target of the current catch-up
  logic [YEAR_W-1:0]   tgt_year;
  logic [MONTH_W-1:0]  tgt_month;
  logic [DAY_W-1:0]    tgt_day;
  logic [HOUR_W-1:0]   tgt_hour;
  logic [MINUTE_W-1:0] tgt_minute;

  logic [ALARM_W-1:0] alarm_word [NUM_ALARMS];
  logic [CNT_W-1:0]   steps;
  logic               stepped;
  logic               fired;
  logic               short_of;
  logic               leap;

  // Leap year detection
  logic [24:0] year_prod;
  logic [5:0]  year_q;
  logic [12:0] year_q100;
  logic        div100;
  logic        leap_next;

  // Minute step
  logic [MINUTE_W:0] min_inc;
  logic [HOUR_W:0]   hour_inc;
  logic [WDAY_W:0]   wd_inc;
  logic [DAY_W:0]    day_inc;
  logic [MONTH_W:0]  month_inc;
  logic [DAY_W-1:0]  days_len;
  logic              match;
  logic [15:0]       steps_wide;

  // Work out leap status of the cursor year, registered
  always_comb begin
    year_prod = 25'(cursor_year) * 25'(RECIP_100);
    year_q    = year_prod[RECIP_SHIFT +: 6];
    year_q100 = {1'b0, year_q, 6'b0} + {2'b0, year_q, 5'b0} + {5'b0, year_q, 2'b0};
    div100    = (year_q100 == 13'(cursor_year));
    leap_next = (cursor_year[1:0] == 2'b00) && (!div100 || (year_q[1:0] == 2'b00));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      leap <= 1'b0;
    end else begin
      leap <= leap_next;
    end
  end

  // Advance the cursor by one minute, carrying through the calendar
  always_comb begin
    cursor_year_next    = cursor_year;
    cursor_month_next   = cursor_month;
    cursor_day_next     = cursor_day;
    cursor_hour_next    = cursor_hour;
    cursor_weekday_next = cursor_weekday;
    min_inc   = {1'b0, cursor_minute} + 1'b1;
    hour_inc  = {1'b0, cursor_hour} + 1'b1;
    wd_inc    = {1'b0, cursor_weekday} + 1'b1;
    day_inc   = {1'b0, cursor_day} + 1'b1;
    month_inc = {1'b0, cursor_month} + 1'b1;
    days_len  = month_days(cursor_month, leap);
    cursor_minute_next = min_inc[MINUTE_W-1:0];
    if (min_inc >= (MINUTE_W+1)'(MINUTES_PER_HOUR)) begin
      cursor_minute_next = '0;
      cursor_hour_next   = hour_inc[HOUR_W-1:0];
      if (hour_inc >= (HOUR_W+1)'(HOURS_PER_DAY)) begin
        cursor_hour_next = '0;
        if (wd_inc >= (WDAY_W+1)'(DAYS_PER_WEEK)) begin
          cursor_weekday_next = WDAY_W'(wd_inc - (WDAY_W+1)'(DAYS_PER_WEEK));
        end else begin
          cursor_weekday_next = wd_inc[WDAY_W-1:0];
        end
        cursor_day_next = day_inc[DAY_W-1:0];
        if (day_inc > {1'b0, days_len}) begin
          cursor_day_next   = RESET_DAY;
          cursor_month_next = month_inc[MONTH_W-1:0];
          if (month_inc >= (MONTH_W+1)'(MONTHS_PER_YEAR)) begin
            cursor_month_next = '0;
            cursor_year_next  = cursor_year + 1'b1;
          end
        end
      end
    end
  end

  // Check enabled alarms against the current cursor
  always_comb begin
    match = 1'b0;
    for (int i = 0; i < NUM_ALARMS; i++) begin
      if (alarm_word[i][ALM_EN_BIT] &&
          (alarm_word[i][ALM_HR_LSB +: HOUR_W] == cursor_hour) &&
          (alarm_word[i][ALM_MN_LSB +: MINUTE_W] == cursor_minute) &&
          (alarm_word[i][ALM_ANY_BIT] ||
           (alarm_word[i][ALM_WD_LSB +: WDAY_W] == cursor_weekday))) begin
        match = 1'b1;
      end
    end
  end

  // Status to the controller
  assign status.earlier =
    {cursor_year, cursor_month, cursor_day, cursor_hour, cursor_minute} <
    CMP_W'({tgt_year, tgt_month, tgt_day, tgt_hour, tgt_minute});
  assign status.at_limit = (steps == CNT_W'(MAX_CATCHUP));

  // Alarm registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_ALARMS; i++) begin
        alarm_word[i] <= '0;
      end
    end else if (cfg_we) begin
      for (int i = 0; i < NUM_ALARMS; i++) begin
        if (cfg_index == CFG_IDX_W'(i)) begin
          alarm_word[i] <= cfg_data;
        end
      end
    end
  end

  // Cursor: load, or step one minute
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_year    <= RESET_YEAR;
      cursor_month   <= RESET_MONTH;
      cursor_day     <= RESET_DAY;
      cursor_hour    <= RESET_HOUR;
      cursor_minute  <= RESET_MINUTE;
      cursor_weekday <= RESET_WEEKDAY;
    end else if (cmd.load) begin
      cursor_year    <= in_year;
      cursor_month   <= in_month;
      cursor_day     <= in_day;
      cursor_hour    <= in_hour;
      cursor_minute  <= in_minute;
      cursor_weekday <= in_weekday;
    end else if (cmd.step) begin
      cursor_year    <= cursor_year_next;
      cursor_month   <= cursor_month_next;
      cursor_day     <= cursor_day_next;
      cursor_hour    <= cursor_hour_next;
      cursor_minute  <= cursor_minute_next;
      cursor_weekday <= cursor_weekday_next;
    end
  end

  // Hold the target for the catch-up
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      tgt_year   <= in_year;
      tgt_month  <= in_month;
      tgt_day    <= in_day;
      tgt_hour   <= in_hour;
      tgt_minute <= in_minute;
    end
  end

  // Step count, alarm and limit flags
  always_ff @(posedge clk) begin
    if (rst) begin
      steps    <= '0;
      stepped  <= 1'b0;
      fired    <= 1'b0;
      short_of <= 1'b0;
    end else begin
      stepped <= cmd.step;
      if (cmd.load || cmd.start) begin
        steps    <= '0;
        fired    <= 1'b0;
        short_of <= 1'b0;
      end else begin
        if (cmd.step) begin
          steps <= steps + 1'b1;
        end
        if (stepped && match) begin
          fired <= 1'b1;
        end
        if (cmd.finish) begin
          short_of <= status.earlier;
        end
      end
    end
  end

  // Result fields
  assign steps_wide       = 16'(steps);
  assign minutes_advanced = (steps_wide > 16'd255) ? 8'hFF : steps_wide[ADV_W-1:0];
  assign alarm_fired      = fired;
  assign not_reached      = short_of;
  assign cur_hour         = cursor_hour;
  assign cur_minute       = cursor_minute;
  assign cur_weekday      = cursor_weekday;

endmodule

@@ sv/calendar_minute_alarm_catchup.sv @@
// Minute calendar cursor with alarm catch-up.
//
// Input channel (in_valid/in_ready): op selects load (cursor := fields) or
// catch-up (step the cursor one minute at a time until it is no earlier than
// the target, at most MAX_CATCHUP minutes, checking the first NUM_ALARMS
// alarm words after every step). Output channel (out_valid/out_ready) returns
// one result per request. Config channel (cfg_valid/cfg_ready/cfg_index/
// cfg_data) writes alarm words; cfg_ready is always high.
//
// A load shows its result in the cycle after acceptance. A catch-up steps the
// cursor one minute per cycle in the step counter loop, then settles the flags
// before it shows its result. The block handles one request at a time: the
// next request is taken the cycle after the result is taken.
//
// Reset sets the cursor to 1970-01-01 00:00, Thursday, and clears the alarm
// words. While the receiver stalls, the result and the cursor hold and no
// new request is taken.
module calendar_minute_alarm_catchup #(
  parameter int NUM_ALARMS  = cmac_pkg::DEFAULT_NUM_ALARMS,
  parameter int MAX_CATCHUP = cmac_pkg::DEFAULT_MAX_CATCHUP
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            op,
  input  logic [cmac_pkg::YEAR_W-1:0]     in_year,
  input  logic [cmac_pkg::MONTH_W-1:0]    in_month,
  input  logic [cmac_pkg::DAY_W-1:0]      in_day,
  input  logic [cmac_pkg::HOUR_W-1:0]     in_hour,
  input  logic [cmac_pkg::MINUTE_W-1:0]   in_minute,
  input  logic [cmac_pkg::WDAY_W-1:0]     in_weekday,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            alarm_fired,
  output logic [cmac_pkg::ADV_W-1:0]      minutes_advanced,
  output logic                            not_reached,
  output logic [cmac_pkg::HOUR_W-1:0]     cur_hour,
  output logic [cmac_pkg::MINUTE_W-1:0]   cur_minute,
  output logic [cmac_pkg::WDAY_W-1:0]     cur_weekday,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [cmac_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cmac_pkg::ALARM_W-1:0]    cfg_data
);
  import cmac_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  cmac_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .op        (op),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  cmac_dp #(
    .NUM_ALARMS  (NUM_ALARMS),
    .MAX_CATCHUP (MAX_CATCHUP)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .status           (status),
    .in_year          (in_year),
    .in_month         (in_month),
    .in_day           (in_day),
    .in_hour          (in_hour),
    .in_minute        (in_minute),
    .in_weekday       (in_weekday),
    .cfg_we           (cfg_valid && cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .alarm_fired      (alarm_fired),
    .minutes_advanced (minutes_advanced),
    .not_reached      (not_reached),
    .cur_hour         (cur_hour),
    .cur_minute       (cur_minute),
    .cur_weekday      (cur_weekday)
  );

endmodule

@@ sv/cmac_chk.sv @@
module cmac_chk (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic                            alarm_fired,
  input logic [cmac_pkg::ADV_W-1:0]      minutes_advanced,
  input logic                            not_reached,
  input logic [cmac_pkg::HOUR_W-1:0]     cur_hour,
  input logic [cmac_pkg::MINUTE_W-1:0]   cur_minute,
  input logic [cmac_pkg::WDAY_W-1:0]     cur_weekday
);
  import cmac_pkg::*;

  // A pending result holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(minutes_advanced) &&
    $stable(alarm_fired) && $stable(not_reached) && $stable(cur_hour) &&
    $stable(cur_minute) && $stable(cur_weekday))
    else $error("result changed while stalled");

  // One request at a time: no new request while a result is pending
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("request taken while result pending");

  // An accepted request leaves the block busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("block idle right after accepting a request");

  // No minute passed means no alarm could fire
  a_no_step_no_alarm: assert property (@(posedge clk) disable iff (rst)
    out_valid && (minutes_advanced == '0) |-> !alarm_fired)
    else $error("alarm reported without any minute advanced");

endmodule

bind calendar_minute_alarm_catchup cmac_chk u_cmac_chk (.*);
